### sv/ilpm_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ilpm_pkg: shared types and constants of the lease pool manager
// Field widths, register indexes, result codes, table entry layout and the
// command/status bundles between the controller and the datapath.
// ----------------------------------------------------------------------------
package ilpm_pkg;

  localparam int TABLE_ENTRIES_DEF = 16;

  localparam int ADDR_W  = 32;
  localparam int MAC_W   = 48;
  localparam int XID_W   = 32;
  localparam int AGE_W   = 17;
  localparam int LEASE_W = 16;
  localparam int STAT_W  = 2;
  localparam int CIDX_W  = 2;

  localparam int IN_DATA_W  = MAC_W + XID_W;
  localparam int OUT_DATA_W = ADDR_W + MAC_W + XID_W;

  localparam logic [ADDR_W-1:0]  POOL_FIRST_RST  = 32'hC0A8_0064;
  localparam logic [ADDR_W-1:0]  POOL_LAST_RST   = 32'hC0A8_006E;
  localparam logic [LEASE_W-1:0] LEASE_TICKS_RST = 16'd60;
  localparam logic [AGE_W-1:0]   AGE_MAX         = 17'h1_FFFF;

  // configuration register indexes
  localparam logic [CIDX_W-1:0] REG_POOL_FIRST  = 2'd0;
  localparam logic [CIDX_W-1:0] REG_POOL_LAST   = 2'd1;
  localparam logic [CIDX_W-1:0] REG_LEASE_TICKS = 2'd2;

  // result status codes
  localparam logic [STAT_W-1:0] ST_NEW       = 2'd0;
  localparam logic [STAT_W-1:0] ST_RENEW     = 2'd1;
  localparam logic [STAT_W-1:0] ST_EXHAUSTED = 2'd2;

  // input action codes
  localparam logic ACT_REQUEST = 1'b0;
  localparam logic ACT_TICK    = 1'b1;

  typedef struct packed {
    logic [ADDR_W-1:0] addr;
    logic [MAC_W-1:0]  mac;
    logic [AGE_W-1:0]  age;
  } entry_t;

  typedef struct packed {
    logic load;       // latch the input word, restart the scan
    logic scan_step;  // read the next table entry
    logic pick;       // choose free entry and lowest open pool offset
    logic addr;       // form the candidate address
    logic finish;     // update the table and load the output register
  } dp_cmd_t;

  typedef struct packed {
    logic is_tick;
    logic scan_last;
    logic out_free;
  } dp_sts_t;

endpackage

### sv/ilpm_datapath.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ilpm_datapath: lease table, scan pipeline and result register
// Holds configuration, valid flags and the entry memory; runs one entry per
// cycle through a check stage for aging, matching and address blocking.
// ----------------------------------------------------------------------------
module ilpm_datapath #(
  parameter int TABLE_ENTRIES = ilpm_pkg::TABLE_ENTRIES_DEF
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  ilpm_pkg::dp_cmd_t                cmd,
  output ilpm_pkg::dp_sts_t                sts,
  input  logic                             in_tuser,
  input  logic [ilpm_pkg::IN_DATA_W-1:0]   in_tdata,
  input  logic                             cfg_valid,
  input  logic [ilpm_pkg::CIDX_W-1:0]      cfg_index,
  input  logic [ilpm_pkg::ADDR_W-1:0]      cfg_data,
  input  logic                             out_tready,
  output logic                             out_tvalid,
  output logic [ilpm_pkg::STAT_W-1:0]      out_tuser,
  output logic [ilpm_pkg::OUT_DATA_W-1:0]  out_tdata
);
  import ilpm_pkg::*;

  localparam int IDXW = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
  localparam int NB   = TABLE_ENTRIES + 1;
  localparam int KW   = $clog2(NB);
  localparam logic [IDXW-1:0]   IDX_LAST = IDXW'(TABLE_ENTRIES - 1);
  localparam logic [ADDR_W-1:0] OFF_LIM  = ADDR_W'(NB);

  // configuration
  logic [ADDR_W-1:0]  pool_first_r, pool_last_r;
  logic [LEASE_W-1:0] lease_ticks_r;

  // current item
  logic               item_tick_r;
  logic [MAC_W-1:0]   item_mac_r;
  logic [XID_W-1:0]   item_xid_r;

  // table
  logic [TABLE_ENTRIES-1:0] valid_r, valid_nxt;
  entry_t                   table_mem [TABLE_ENTRIES];
  entry_t                   rd_data_r;
  logic                     wr_en;
  logic [IDXW-1:0]          wr_idx;
  entry_t                   wr_data;

  // scan
  logic [IDXW-1:0] idx_r;
  logic            chk_v_r;
  logic [IDXW-1:0] chk_idx_r;
  logic            hit_r, hit_nxt;
  logic [IDXW-1:0] hit_idx_r, hit_idx_nxt;
  logic [ADDR_W-1:0] hit_addr_r, hit_addr_nxt;
  logic [NB-1:0]   blocked_r, blocked_nxt;

  // pick / address
  logic            free_ok_r, free_found;
  logic [IDXW-1:0] free_idx_r, free_idx;
  logic            k_ok_r, k_found;
  logic [KW-1:0]   k_r, k_sel;
  logic [ADDR_W:0] cand_sum;
  logic [ADDR_W-1:0] cand_r;
  logic            grant_ok_r;

  // check stage
  entry_t            ent;
  logic              ent_v;
  logic [AGE_W-1:0]  age_inc;
  logic              expire;
  logic [ADDR_W:0]   off;

  // output register
  logic              out_valid_r;
  logic [STAT_W-1:0] out_status_r;
  logic [ADDR_W-1:0] out_addr_r;
  logic [MAC_W-1:0]  out_mac_r;
  logic [XID_W-1:0]  out_xid_r;
  logic              grant_new;

  assign ent       = rd_data_r;
  assign ent_v     = valid_r[chk_idx_r];
  assign age_inc   = (ent.age == AGE_MAX) ? ent.age : ent.age + 1'b1;
  assign expire    = age_inc > {1'b0, lease_ticks_r};
  assign off       = {1'b0, ent.addr} - {1'b0, pool_first_r};
  assign grant_new = !hit_r && free_ok_r && grant_ok_r;
  assign cand_sum  = {1'b0, pool_first_r} + {{(ADDR_W + 1 - KW){1'b0}}, k_r};

  // check stage: age on ticks, match and mark blocked offsets on requests
  always_comb begin
    valid_nxt    = valid_r;
    hit_nxt      = hit_r;
    hit_idx_nxt  = hit_idx_r;
    hit_addr_nxt = hit_addr_r;
    blocked_nxt  = blocked_r;
    wr_en        = 1'b0;
    wr_idx       = chk_idx_r;
    wr_data      = '{addr: ent.addr, mac: ent.mac, age: age_inc};
    if (chk_v_r && ent_v) begin
      if (item_tick_r) begin
        if (expire) begin
          valid_nxt[chk_idx_r] = 1'b0;
        end else begin
          wr_en = 1'b1;
        end
      end else begin
        if (!hit_r && ent.mac == item_mac_r) begin
          hit_nxt      = 1'b1;
          hit_idx_nxt  = chk_idx_r;
          hit_addr_nxt = ent.addr;
        end
        if (!off[ADDR_W] && off[ADDR_W-1:0] < OFF_LIM) begin
          blocked_nxt[off[KW-1:0]] = 1'b1;
        end
      end
    end
    if (cmd.finish) begin
      if (hit_r) begin
        wr_en   = 1'b1;
        wr_idx  = hit_idx_r;
        wr_data = '{addr: hit_addr_r, mac: item_mac_r, age: '0};
      end else if (grant_new) begin
        wr_en   = 1'b1;
        wr_idx  = free_idx_r;
        wr_data = '{addr: cand_r, mac: item_mac_r, age: '0};
        valid_nxt[free_idx_r] = 1'b1;
      end
    end
  end

  // lowest free entry and lowest open pool offset
  always_comb begin
    free_found = 1'b0;
    free_idx   = '0;
    for (int i = TABLE_ENTRIES - 1; i >= 0; i--) begin
      if (!valid_r[i]) begin
        free_found = 1'b1;
        free_idx   = IDXW'(i);
      end
    end
  end

  always_comb begin
    k_found = 1'b0;
    k_sel   = '0;
    for (int j = NB - 1; j >= 0; j--) begin
      if (!blocked_r[j]) begin
        k_found = 1'b1;
        k_sel   = KW'(j);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      table_mem[wr_idx] <= wr_data;
    end
    if (cmd.scan_step) begin
      rd_data_r <= table_mem[idx_r];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pool_first_r  <= POOL_FIRST_RST;
      pool_last_r   <= POOL_LAST_RST;
      lease_ticks_r <= LEASE_TICKS_RST;
      valid_r       <= '0;
      idx_r         <= '0;
      chk_v_r       <= 1'b0;
      hit_r         <= 1'b0;
      blocked_r     <= '0;
      out_valid_r   <= 1'b0;
    end else begin
      if (cfg_valid) begin
        unique case (cfg_index)
          REG_POOL_FIRST:  pool_first_r  <= cfg_data;
          REG_POOL_LAST:   pool_last_r   <= cfg_data;
          REG_LEASE_TICKS: lease_ticks_r <= cfg_data[LEASE_W-1:0];
          default: ;
        endcase
      end
      valid_r <= valid_nxt;
      chk_v_r <= cmd.scan_step;
      if (cmd.load) begin
        idx_r     <= '0;
        hit_r     <= 1'b0;
        blocked_r <= '0;
      end else begin
        hit_r     <= hit_nxt;
        blocked_r <= blocked_nxt;
        if (cmd.scan_step) begin
          idx_r <= idx_r + 1'b1;
        end
      end
      if (cmd.finish) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      item_tick_r <= in_tuser;
      item_mac_r  <= in_tdata[MAC_W-1:0];
      item_xid_r  <= in_tdata[IN_DATA_W-1:MAC_W];
    end
    chk_idx_r  <= idx_r;
    hit_idx_r  <= hit_idx_nxt;
    hit_addr_r <= hit_addr_nxt;
    if (cmd.pick) begin
      free_ok_r  <= free_found;
      free_idx_r <= free_idx;
      k_ok_r     <= k_found;
      k_r        <= k_sel;
    end
    if (cmd.addr) begin
      cand_r     <= cand_sum[ADDR_W-1:0];
      grant_ok_r <= k_ok_r && (cand_sum <= {1'b0, pool_last_r});
    end
    if (cmd.finish) begin
      out_mac_r <= item_mac_r;
      out_xid_r <= item_xid_r;
      if (hit_r) begin
        out_status_r <= ST_RENEW;
        out_addr_r   <= hit_addr_r;
      end else if (grant_new) begin
        out_status_r <= ST_NEW;
        out_addr_r   <= cand_r;
      end else begin
        out_status_r <= ST_EXHAUSTED;
        out_addr_r   <= '0;
      end
    end
  end

  assign sts.is_tick   = (item_tick_r == ACT_TICK);
  assign sts.scan_last = (idx_r == IDX_LAST);
  assign sts.out_free  = !out_valid_r || out_tready;

  assign out_tvalid = out_valid_r;
  assign out_tuser  = out_status_r;
  assign out_tdata  = {out_xid_r, out_mac_r, out_addr_r};

`ifndef SYNTHESIS
  a_new_in_pool: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_status_r == ST_NEW) |->
      (out_addr_r >= pool_first_r && out_addr_r <= pool_last_r))
    else $error("new lease outside the pool");

  a_new_claims_free: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.finish && grant_new) |->
      (!valid_r[free_idx_r] ##1 valid_r[$past(free_idx_r)]))
    else $error("new lease did not take a free entry");

  a_renew_valid: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.finish && hit_r) |-> valid_r[hit_idx_r])
    else $error("renewal of an entry that is not valid");
`endif

endmodule

### sv/ilpm_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ilpm_ctrl: sequencer of the lease pool manager
// Accepts a word, steps the datapath through the table scan, then for a
// request through the pick, address and result phases.
// ----------------------------------------------------------------------------
module ilpm_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_tvalid,
  output logic              in_tready,
  output ilpm_pkg::dp_cmd_t cmd,
  input  ilpm_pkg::dp_sts_t sts
);
  import ilpm_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE,
    S_SCAN,
    S_DRAIN,
    S_PICK,
    S_ADDR,
    S_FINISH
  } state_t;

  state_t state_r, state_nxt;

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE:   if (in_tvalid) state_nxt = S_SCAN;
      S_SCAN:   if (sts.scan_last) state_nxt = S_DRAIN;
      S_DRAIN:  state_nxt = sts.is_tick ? S_IDLE : S_PICK;
      S_PICK:   state_nxt = S_ADDR;
      S_ADDR:   state_nxt = S_FINISH;
      S_FINISH: if (sts.out_free) state_nxt = S_IDLE;
      default:  state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  assign in_tready     = (state_r == S_IDLE);
  assign cmd.load      = (state_r == S_IDLE) && in_tvalid;
  assign cmd.scan_step = (state_r == S_SCAN);
  assign cmd.pick      = (state_r == S_PICK);
  assign cmd.addr      = (state_r == S_ADDR);
  // hold the result until the output register can take it
  assign cmd.finish    = (state_r == S_FINISH) && sts.out_free;

`ifndef SYNTHESIS
  a_finish_free: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.finish |-> sts.out_free)
    else $error("result loaded over a waiting word");

  a_drain_after_last: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_DRAIN) |-> $past(cmd.scan_step && sts.scan_last))
    else $error("scan ended before the last entry");

  a_tick_returns: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_DRAIN && sts.is_tick) |=> in_tready)
    else $error("tick did not return to idle");
`endif

endmodule

### sv/ip_lease_pool_manager.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ip_lease_pool_manager: lease table for an address pool
// Renews a known client, grants the lowest open pool address to a new one,
// or reports the pool exhausted; tick words age and expire leases.
// ----------------------------------------------------------------------------
// channel  dir   handshake              payload
// in_      in    in_tvalid/in_tready    tuser action, tdata mac + transaction id
// out_     out   out_tvalid/out_tready  tuser status, tdata addr + mac + xid
// cfg_     in    cfg_valid/cfg_ready    cfg_index register, cfg_data value
//
// A tick runs the one-entry-per-cycle scan over the single read port of the
// table memory; a request then adds the pick, address and result phases.
// Reset clears the valid flags at once; there is no clearing pass.
// A waiting result does not block the next word; a request only stalls in
// its last phase while the output register still holds an untaken word.
// cfg_ready is always high.
// ----------------------------------------------------------------------------
module ip_lease_pool_manager #(
  parameter int TABLE_ENTRIES = ilpm_pkg::TABLE_ENTRIES_DEF
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_tvalid,
  output logic                             in_tready,
  input  logic                             in_tuser,   // action
  input  logic [ilpm_pkg::IN_DATA_W-1:0]   in_tdata,   // client_hw_addr, transaction_id
  output logic                             out_tvalid,
  input  logic                             out_tready,
  output logic [ilpm_pkg::STAT_W-1:0]      out_tuser,  // status
  output logic [ilpm_pkg::OUT_DATA_W-1:0]  out_tdata,  // granted_address, echo_mac,
                                                       // echo_transaction
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic [ilpm_pkg::CIDX_W-1:0]      cfg_index,
  input  logic [ilpm_pkg::ADDR_W-1:0]      cfg_data
);
  import ilpm_pkg::*;

  dp_cmd_t cmd;
  dp_sts_t sts;

  assign cfg_ready = 1'b1;

  ilpm_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .cmd       (cmd),
    .sts       (sts)
  );

  ilpm_datapath #(
    .TABLE_ENTRIES (TABLE_ENTRIES)
  ) u_datapath (
    .clk        (clk),
    .rst_n      (rst_n),
    .cmd        (cmd),
    .sts        (sts),
    .in_tuser   (in_tuser),
    .in_tdata   (in_tdata),
    .cfg_valid  (cfg_valid),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .out_tready (out_tready),
    .out_tvalid (out_tvalid),
    .out_tuser  (out_tuser),
    .out_tdata  (out_tdata)
  );

endmodule

### tb/lease_table_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lease_table_checker: result checker for the lease pool manager
// Watches the request, result and register channels, keeps its own copy of
// the lease table and the pool registers, and checks each result word field
// by field against the oldest predicted lease reply.
// ----------------------------------------------------------------------------
module lease_table_checker #(
  parameter int TABLE_ENTRIES = ilpm_pkg::TABLE_ENTRIES_DEF
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_tvalid,
  input  logic                             in_tready,
  input  logic                             in_tuser,   // action
  input  logic [ilpm_pkg::IN_DATA_W-1:0]   in_tdata,   // client_hw_addr, transaction_id
  input  logic                             out_tvalid,
  input  logic                             out_tready,
  input  logic [ilpm_pkg::STAT_W-1:0]      out_tuser,  // status
  input  logic [ilpm_pkg::OUT_DATA_W-1:0]  out_tdata,  // granted_address, echo_mac,
                                                       // echo_transaction
  input  logic                             cfg_valid,
  input  logic                             cfg_ready,
  input  logic [ilpm_pkg::CIDX_W-1:0]      cfg_index,
  input  logic [ilpm_pkg::ADDR_W-1:0]      cfg_data,
  output int                               error_count,
  output int                               leases_pending
);
  import ilpm_pkg::*;

  typedef struct packed {
    logic [STAT_W-1:0] status;
    logic [ADDR_W-1:0] addr;
    logic [MAC_W-1:0]  mac;
    logic [XID_W-1:0]  xid;
  } lease_reply_t;

  logic [ADDR_W-1:0]  pool_first;
  logic [ADDR_W-1:0]  pool_last;
  logic [LEASE_W-1:0] lease_ticks;

  logic              lt_valid [TABLE_ENTRIES];
  logic [ADDR_W-1:0] lt_addr  [TABLE_ENTRIES];
  logic [MAC_W-1:0]  lt_mac   [TABLE_ENTRIES];
  logic [AGE_W-1:0]  lt_age   [TABLE_ENTRIES];

  lease_reply_t lease_replies [$];
  lease_reply_t want;

  function automatic bit addr_in_use(input logic [ADDR_W-1:0] a);
    for (int i = 0; i < TABLE_ENTRIES; i++)
      if (lt_valid[i] && lt_addr[i] == a) return 1'b1;
    return 1'b0;
  endfunction

  task automatic drop_entry(input int i);
    lt_valid[i] = 1'b0;
    lt_addr[i]  = '0;
    lt_mac[i]   = '0;
    lt_age[i]   = '0;
  endtask

  task automatic apply_lease_word(input logic act, input logic [MAC_W-1:0] mac,
                                  input logic [XID_W-1:0] xid);
    int           hit;
    int           slot;
    bit           found;
    logic [ADDR_W:0] cand;
    lease_reply_t r;
    hit   = -1;
    slot  = -1;
    found = 1'b0;
    if (act == ACT_TICK) begin
      for (int i = 0; i < TABLE_ENTRIES; i++) begin
        if (lt_valid[i]) begin
          if (lt_age[i] != AGE_MAX) lt_age[i] = lt_age[i] + 1'b1;
          if (lt_age[i] > {1'b0, lease_ticks}) drop_entry(i);
        end
      end
      return;
    end
    for (int i = 0; i < TABLE_ENTRIES; i++)
      if (hit < 0 && lt_valid[i] && lt_mac[i] == mac) hit = i;
    r.mac  = mac;
    r.xid  = xid;
    r.addr = '0;
    if (hit >= 0) begin
      lt_age[hit] = '0;
      r.addr      = lt_addr[hit];
      r.status    = ST_RENEW;
    end else begin
      for (int i = 0; i < TABLE_ENTRIES; i++)
        if (slot < 0 && !lt_valid[i]) slot = i;
      // each valid entry blocks at most one candidate
      cand = {1'b0, pool_first};
      for (int k = 0; k <= TABLE_ENTRIES && !found && cand <= {1'b0, pool_last}; k++) begin
        if (!addr_in_use(cand[ADDR_W-1:0])) begin
          found  = 1'b1;
          r.addr = cand[ADDR_W-1:0];
        end else begin
          cand = cand + 1'b1;
        end
      end
      if (slot >= 0 && found) begin
        lt_valid[slot] = 1'b1;
        lt_addr[slot]  = r.addr;
        lt_mac[slot]   = mac;
        lt_age[slot]   = '0;
        r.status       = ST_NEW;
      end else begin
        r.addr   = '0;
        r.status = ST_EXHAUSTED;
      end
    end
    lease_replies.push_back(r);
  endtask

  task automatic check_field(input string name, input logic [63:0] exp_val,
                             input logic [63:0] got_val);
    if (got_val !== exp_val) begin
      $error("%s: expected %h, got %h", name, exp_val, got_val);
      error_count++;
    end
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      error_count = 0;
      pool_first  = POOL_FIRST_RST;
      pool_last   = POOL_LAST_RST;
      lease_ticks = LEASE_TICKS_RST;
      for (int i = 0; i < TABLE_ENTRIES; i++) drop_entry(i);
      lease_replies.delete();
    end else begin
      // retire before predicting: a result never answers a same-edge request
      if (out_tvalid && out_tready) begin
        if (lease_replies.size() == 0) begin
          $error("result word with no request outstanding: tuser %h tdata %h",
                 out_tuser, out_tdata);
          error_count++;
        end else begin
          want = lease_replies.pop_front();
          check_field("status", 64'(want.status), 64'(out_tuser));
          check_field("granted_address", 64'(want.addr), 64'(out_tdata[ADDR_W-1:0]));
          check_field("echo_mac", 64'(want.mac), 64'(out_tdata[ADDR_W +: MAC_W]));
          check_field("echo_transaction", 64'(want.xid),
                      64'(out_tdata[ADDR_W+MAC_W +: XID_W]));
        end
      end
      if (in_tvalid && in_tready)
        apply_lease_word(in_tuser, in_tdata[MAC_W-1:0], in_tdata[MAC_W +: XID_W]);
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          REG_POOL_FIRST:  pool_first  = cfg_data;
          REG_POOL_LAST:   pool_last   = cfg_data;
          REG_LEASE_TICKS: lease_ticks = cfg_data[LEASE_W-1:0];
          default: ;
        endcase
      end
    end
    leases_pending <= lease_replies.size();
  end

endmodule

### tb/ip_lease_pool_manager_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ip_lease_pool_manager_tb: testbench of the lease pool manager
// Directed requests and ticks at the field and pool extremes, then phases of
// random traffic over a small set of clients under changing pool settings,
// with random idling on both channels and one long result back-pressure.
// ----------------------------------------------------------------------------
module ip_lease_pool_manager_tb;
  import ilpm_pkg::*;

  localparam int ENTRIES        = TABLE_ENTRIES_DEF;
  localparam int WATCHDOG_LIMIT = 5000;
  localparam int RX_HOLD_CYCLES = 400;
  localparam int PHASES         = 10;
  localparam int PHASE_WORDS    = 75;
  localparam int CLIENTS        = 20;
  localparam logic [CIDX_W-1:0] REG_UNUSED = 2'd3;

  logic                  clk        = 1'b0;
  logic                  rst_n      = 1'b0;
  logic                  in_tvalid  = 1'b0;
  logic                  in_tuser   = 1'b0;
  logic [IN_DATA_W-1:0]  in_tdata   = '0;
  logic                  out_tready = 1'b0;
  logic                  cfg_valid  = 1'b0;
  logic [CIDX_W-1:0]     cfg_index  = '0;
  logic [ADDR_W-1:0]     cfg_data   = '0;
  logic                  in_tready;
  logic                  out_tvalid;
  logic [STAT_W-1:0]     out_tuser;
  logic [OUT_DATA_W-1:0] out_tdata;
  logic                  cfg_ready;

  int error_count;
  int leases_pending;
  int idle_cycles = 0;
  int rx_run      = 0;
  int rx_stall    = 0;
  bit calm        = 1'b0;
  bit rx_hold_req = 1'b0;

  logic [MAC_W-1:0] clients [CLIENTS];

  always #6 clk = ~clk;

  ip_lease_pool_manager #(.TABLE_ENTRIES(ENTRIES)) uut (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tuser(in_tuser), .in_tdata(in_tdata),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tuser(out_tuser),
    .out_tdata(out_tdata),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  lease_table_checker #(.TABLE_ENTRIES(ENTRIES)) lease_chk (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tuser(in_tuser), .in_tdata(in_tdata),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tuser(out_tuser),
    .out_tdata(out_tdata),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .error_count(error_count), .leases_pending(leases_pending)
  );

  function automatic int idle_len();
    int r;
    if (calm) return 0;
    r = $urandom_range(0, 99);
    if (r < 50) return 0;
    if (r < 92) return $urandom_range(1, 4);
    return $urandom_range(15, 60);
  endfunction

  function automatic logic [MAC_W-1:0] rand_mac();
    logic [63:0] raw;
    raw = {$urandom, $urandom};
    return raw[MAC_W-1:0];
  endfunction

  // hold the word until taken, then idle for a random gap
  task automatic send_word(input logic act, input logic [MAC_W-1:0] mac,
                           input logic [XID_W-1:0] xid);
    int gap;
    in_tvalid <= 1'b1;
    in_tuser  <= act;
    in_tdata  <= {xid, mac};
    do @(posedge clk); while (!in_tready);
    gap = idle_len();
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  // stop sending, wait for every reply, then let a trailing tick finish
  task automatic drain_results();
    in_tvalid <= 1'b0;
    do @(posedge clk); while (leases_pending != 0);
    repeat (ENTRIES + 8) @(posedge clk);
  endtask

  task automatic program_pool(input logic [ADDR_W-1:0] first, input logic [ADDR_W-1:0] last,
                              input logic [LEASE_W-1:0] lease);
    logic [CIDX_W-1:0] idx   [4];
    logic [ADDR_W-1:0] value [4];
    idx[0]   = REG_POOL_FIRST;
    idx[1]   = REG_POOL_LAST;
    idx[2]   = REG_LEASE_TICKS;
    idx[3]   = REG_UNUSED;
    value[0] = first;
    value[1] = last;
    value[2] = {16'($urandom_range(0, 16'hFFFF)), lease};
    value[3] = $urandom;
    for (int i = 0; i < 4; i++) begin
      cfg_valid <= 1'b1;
      cfg_index <= idx[i];
      cfg_data  <= value[i];
      do @(posedge clk); while (!cfg_ready);
    end
    cfg_valid <= 1'b0;
  endtask

  // result side: random ready runs and stalls, or one long hold on request
  initial begin
    forever begin
      @(posedge clk);
      if (rx_hold_req) begin
        rx_hold_req = 1'b0;
        rx_run      = 0;
        rx_stall    = RX_HOLD_CYCLES;
      end
      if (rx_run == 0 && rx_stall == 0) begin
        rx_run   = $urandom_range(1, 40);
        rx_stall = idle_len();
      end
      if (rx_run > 0) begin
        out_tready <= 1'b1;
        rx_run--;
      end else begin
        out_tready <= 1'b0;
        rx_stall--;
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_tvalid && in_tready) || (out_tvalid && out_tready) ||
        (cfg_valid && cfg_ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    int kind;
    int tick_pct;
    int roll;
    logic [ADDR_W-1:0] base;
    logic [MAC_W-1:0]  mac_a;
    logic [MAC_W-1:0]  mac_b;
    mac_a = rand_mac();
    mac_b = rand_mac();
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // reset pool: zero client must not match empty entries, then a renewal
    send_word(ACT_REQUEST, '0, '0);
    send_word(ACT_REQUEST, '1, '1);
    send_word(ACT_REQUEST, '0, $urandom);
    send_word(ACT_TICK, '1, '1);
    send_word(ACT_REQUEST, 48'h0000_0000_0001, $urandom);
    drain_results();

    // whole address space, shortest lease: address zero is the lowest open one
    program_pool('0, '1, 16'd1);
    send_word(ACT_REQUEST, 48'h8000_0000_0000, $urandom);
    send_word(ACT_TICK, rand_mac(), $urandom);
    send_word(ACT_TICK, rand_mac(), $urandom);
    send_word(ACT_REQUEST, '0, $urandom);
    drain_results();

    // single top address; renewal outside the new pool keeps its address
    program_pool('1, '1, 16'hFFFF);
    send_word(ACT_REQUEST, mac_a, $urandom);
    send_word(ACT_REQUEST, mac_b, $urandom);
    send_word(ACT_REQUEST, '0, $urandom);
    drain_results();

    // empty pool, zero lease: the next tick frees every entry
    program_pool(32'd5, 32'd4, 16'd0);
    send_word(ACT_REQUEST, rand_mac(), $urandom);
    send_word(ACT_REQUEST, mac_a, $urandom);
    send_word(ACT_TICK, rand_mac(), $urandom);
    send_word(ACT_REQUEST, mac_a, $urandom);
    drain_results();

    for (int ph = 0; ph < PHASES; ph++) begin
      kind     = ph % 6;
      tick_pct = $urandom_range(10, 40);
      calm     = (ph == 3);
      for (int i = 0; i < CLIENTS; i++) clients[i] = rand_mac();
      case (kind)
        0: begin
          base = POOL_FIRST_RST + $urandom_range(0, 8);
          program_pool(base, base + 10, LEASE_W'($urandom_range(2, 12)));
        end
        1: begin
          // long leases over a wide pool: the table fills up
          program_pool($urandom_range(0, 100), '1, 16'hFFFF);
          tick_pct = 3;
        end
        2: program_pool(32'hFFFF_FFF8, '1, LEASE_W'($urandom_range(1, 6)));
        3: begin
          base = $urandom;
          program_pool(base, base + $urandom_range(0, 3), LEASE_W'($urandom_range(1, 30)));
        end
        4: begin
          base = $urandom | 32'h100;
          program_pool(base, base - $urandom_range(1, 255), LEASE_W'($urandom_range(1, 4)));
        end
        default: begin
          base = $urandom;
          program_pool(base, base, LEASE_W'($urandom_range(0, 3)));
        end
      endcase
      if (ph == 1) rx_hold_req = 1'b1;
      for (int n = 0; n < PHASE_WORDS; n++) begin
        roll = $urandom_range(0, 99);
        if (roll < tick_pct)
          send_word(ACT_TICK, rand_mac(), $urandom);
        else if (roll < tick_pct + 8)
          send_word(ACT_REQUEST, rand_mac(), $urandom);
        else
          send_word(ACT_REQUEST, clients[$urandom_range(0, CLIENTS-1)], $urandom);
      end
      drain_results();
    end

    if (error_count == 0 && leases_pending == 0)
      $display("TEST PASSED");
    else
      $display("TEST FAILED");
    $finish;
  end

endmodule

### sim.f
sv/ilpm_pkg.sv
sv/ilpm_datapath.sv
sv/ilpm_ctrl.sv
sv/ip_lease_pool_manager.sv
tb/lease_table_checker.sv
tb/ip_lease_pool_manager_tb.sv
